[design/mhp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and helpers for the 802.15.4 MAC header parser.
// Holds the header layout decoder and the result record; depends on nothing.
package mhp_pkg;

	localparam int PosW = 8;
	localparam int AtW  = 5;

	localparam logic [1:0] ModeNone  = 2'd0;
	localparam logic [1:0] ModeShort = 2'd2;
	localparam logic [1:0] ModeLong  = 2'd3;

	typedef struct packed {
		logic [1:0]     dmode;
		logic [1:0]     smode;
		logic           omit;
		logic           dpan;
		logic           dshort;
		logic           span;
		logic           sshort;
		logic [AtW-1:0] dpan_at;
		logic [AtW-1:0] dshort_at;
		logic [AtW-1:0] span_at;
		logic [AtW-1:0] sshort_at;
		logic [AtW-1:0] length;
	} layout_t;

	typedef struct packed {
		logic        parse_ok;
		logic [2:0]  frame_type;
		logic [7:0]  seq_num;
		logic [1:0]  dest_addr_mode;
		logic [1:0]  src_addr_mode;
		logic        has_dest_pan;
		logic [15:0] dest_pan;
		logic        has_src_pan;
		logic [15:0] src_pan;
		logic [15:0] dest_short;
		logic [15:0] src_short;
	} result_t;

	function automatic layout_t plan(input logic [15:0] cw);
		layout_t        l;
		logic [AtW-1:0] at;
		l.dmode  = cw[11:10];
		l.smode  = cw[15:14];
		l.omit   = cw[6] && (l.dmode != ModeNone);
		l.dpan   = l.dmode != ModeNone;
		l.dshort = l.dmode == ModeShort;
		l.span   = (l.smode != ModeNone) && !l.omit;
		l.sshort = l.smode == ModeShort;
		at = AtW'(3);
		l.dpan_at = at;
		if (l.dpan) begin
			at = at + AtW'(2);
		end
		l.dshort_at = at;
		if (l.dmode == ModeShort) begin
			at = at + AtW'(2);
		end else if (l.dmode == ModeLong) begin
			at = at + AtW'(8);
		end
		l.span_at = at;
		if (l.span) begin
			at = at + AtW'(2);
		end
		l.sshort_at = at;
		if (l.smode == ModeShort) begin
			at = at + AtW'(2);
		end else if (l.smode == ModeLong) begin
			at = at + AtW'(8);
		end
		l.length = at;
		return l;
	endfunction

	function automatic logic [15:0] put16(input logic [15:0] cur, input logic present,
			input logic [AtW-1:0] at, input logic [PosW-1:0] p, input logic [7:0] b);
		logic [PosW-1:0] lo;
		logic [15:0]     v;
		lo = PosW'(at);
		v  = cur;
		if (present) begin
			if (p == lo) begin
				v = {cur[15:8], b};
			end else if (p == lo + PosW'(1)) begin
				v = {b, cur[7:0]};
			end
		end
		return v;
	endfunction

endpackage

[design/mhp_capture.sv]
`timescale 1ns / 1ps
// Byte position counter and header field capture registers.
// Produces the result record for the current beat; uses mhp_pkg.
module mhp_capture (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        frame_byte,
	input  logic              last_byte,
	output mhp_pkg::result_t  res
);
	import mhp_pkg::*;

	logic [PosW-1:0] pos_q;
	logic [15:0]     ctrl_q, ctrl_n;
	logic [7:0]      seq_q, seq_n;
	logic [15:0]     dpan_q, dpan_n;
	logic [15:0]     span_q, span_n;
	logic [15:0]     dshort_q, dshort_n;
	logic [15:0]     sshort_q, sshort_n;
	layout_t         lay;
	logic            ok;

	assign lay = plan(ctrl_q);

	always_comb begin
		ctrl_n   = ctrl_q;
		seq_n    = seq_q;
		dpan_n   = dpan_q;
		span_n   = span_q;
		dshort_n = dshort_q;
		sshort_n = sshort_q;
		if (pos_q == PosW'(0)) begin
			ctrl_n = {ctrl_q[15:8], frame_byte};
		end else if (pos_q == PosW'(1)) begin
			ctrl_n = {frame_byte, ctrl_q[7:0]};
		end else if (pos_q == PosW'(2)) begin
			seq_n = frame_byte;
		end else begin
			dpan_n   = put16(dpan_q, lay.dpan, lay.dpan_at, pos_q, frame_byte);
			dshort_n = put16(dshort_q, lay.dshort, lay.dshort_at, pos_q, frame_byte);
			span_n   = put16(span_q, lay.span, lay.span_at, pos_q, frame_byte);
			sshort_n = put16(sshort_q, lay.sshort, lay.sshort_at, pos_q, frame_byte);
		end
	end

	// The frame holds the header when the last byte sits at length - 1 or later.
	assign ok = pos_q >= PosW'(lay.length - AtW'(1));

	always_comb begin
		res = '0;
		if (ok) begin
			res.parse_ok       = 1'b1;
			res.frame_type     = ctrl_q[2:0];
			res.seq_num        = seq_n;
			res.dest_addr_mode = lay.dmode;
			res.src_addr_mode  = lay.smode;
			res.has_dest_pan   = lay.dpan;
			res.dest_pan       = lay.dpan ? dpan_n : 16'h0000;
			res.has_src_pan    = lay.smode != ModeNone;
			if (lay.smode != ModeNone) begin
				res.src_pan = lay.omit ? dpan_n : span_n;
			end
			res.dest_short     = lay.dshort ? dshort_n : 16'h0000;
			res.src_short      = lay.sshort ? sshort_n : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ctrl_q   <= '0;
			seq_q    <= '0;
			dpan_q   <= '0;
			span_q   <= '0;
			dshort_q <= '0;
			sshort_q <= '0;
		end else if (accept) begin
			ctrl_q   <= ctrl_n;
			seq_q    <= seq_n;
			dpan_q   <= dpan_n;
			span_q   <= span_n;
			dshort_q <= dshort_n;
			sshort_q <= sshort_n;
			if (last_byte) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> pos_q == '0)
		else $error("byte position not cleared after last beat");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_byte && pos_q != '1 |=> pos_q == $past(pos_q) + PosW'(1))
		else $error("byte position did not advance");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(pos_q))
		else $error("byte position moved without a beat");

endmodule

[design/mac_header_parser_802154_unit.sv]
`timescale 1ns / 1ps
// Top level of the 802.15.4 MAC header parser: handshakes and result register.
// Instantiates mhp_capture; uses mhp_pkg.
//
// The parser takes one frame byte per cycle, starting at the frame control
// field, unless a last beat is held off. The beat marked last yields one
// result, registered and presented the next cycle. Bytes that are not last
// are accepted even while a result waits; a last beat is held off only
// while the result register is full and stalled downstream.
module mac_header_parser_802154_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        parse_ok,
	output logic [2:0]  frame_type,
	output logic [7:0]  seq_num,
	output logic [1:0]  dest_addr_mode,
	output logic [1:0]  src_addr_mode,
	output logic        has_dest_pan,
	output logic [15:0] dest_pan,
	output logic        has_src_pan,
	output logic [15:0] src_pan,
	output logic [15:0] dest_short,
	output logic [15:0] src_short
);
	import mhp_pkg::*;

	logic    accept;
	logic    valid_q;
	result_t res;
	result_t res_q;

	assign frame_stall = valid_q && result_stall && last_byte;
	assign accept      = frame_valid && !frame_stall;

	mhp_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			res_q <= res;
		end
	end

	assign result_valid   = valid_q;
	assign parse_ok       = res_q.parse_ok;
	assign frame_type     = res_q.frame_type;
	assign seq_num        = res_q.seq_num;
	assign dest_addr_mode = res_q.dest_addr_mode;
	assign src_addr_mode  = res_q.src_addr_mode;
	assign has_dest_pan   = res_q.has_dest_pan;
	assign dest_pan       = res_q.dest_pan;
	assign has_src_pan    = res_q.has_src_pan;
	assign src_pan        = res_q.src_pan;
	assign dest_short     = res_q.dest_short;
	assign src_short      = res_q.src_short;

	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(accept && last_byte))
		else $error("result appeared without a last beat");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.parse_ok |-> res_q.frame_type == 3'd0 && res_q.seq_num == 8'd0
			&& res_q.dest_pan == 16'd0 && res_q.src_pan == 16'd0
			&& res_q.dest_short == 16'd0 && res_q.src_short == 16'd0)
		else $error("failed parse carries nonzero fields");

	a_dpan_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.parse_ok |-> res_q.has_dest_pan == (res_q.dest_addr_mode != ModeNone))
		else $error("destination PAN flag disagrees with address mode");

endmodule
